>>> rtl/odp_pkg.sv
// shared types and constants for the offset int8 dot product
`timescale 1ns / 1ps

package odp_pkg;

   // fixed field widths
   localparam int BYTE_W     = 8;
   localparam int OFF_W      = 9;
   localparam int LEN_W      = 16;
   localparam int DOT_W      = 32;
   localparam int WORD_W     = 64;
   localparam int WORD_LANES = WORD_W / BYTE_W;

   // one offset-adjusted element, and the product of two of them
   localparam int OPND_W = OFF_W + 1;
   localparam int PROD_W = 2 * OPND_W;

   // position arithmetic with room for position plus lane count
   localparam int POS_EXT_W = LEN_W + 1;

   // configuration port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_ACT_OFFSET = 2'd0,
      CSR_WGT_OFFSET = 2'd1,
      CSR_VEC_LEN    = 2'd2
   } csr_index_type;

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic [OFF_W-1:0] act_offset;
      logic [OFF_W-1:0] wgt_offset;
      logic [LEN_W-1:0] vec_len;
   } cfg_type;

   // per-stage control that travels with a beat
   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctrl_type;

endpackage

>>> rtl/odp_csr.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps

module odp_csr
   import odp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   csr_index_type index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = csr_index_type'(paddr[ADDR_W-1:2]);

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_ACT_OFFSET: cfg_in.act_offset = pwdata[OFF_W-1:0];
            CSR_WGT_OFFSET: cfg_in.wgt_offset = pwdata[OFF_W-1:0];
            CSR_VEC_LEN:    cfg_in.vec_len    = pwdata[LEN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (index)
         CSR_ACT_OFFSET: prdata = {{(DATA_W-OFF_W){1'b0}}, cfg_ff.act_offset};
         CSR_WGT_OFFSET: prdata = {{(DATA_W-OFF_W){1'b0}}, cfg_ff.wgt_offset};
         CSR_VEC_LEN:    prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_ff.vec_len};
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/odp_lane_mul.sv
// one lane: offset add, lane masking and registered multiply
`timescale 1ns / 1ps

module odp_lane_mul
   import odp_pkg::*;
(
   input  logic                     clock,
   input  logic                     enable,
   input  logic                     active,
   input  logic [BYTE_W-1:0]        act_byte,
   input  logic [BYTE_W-1:0]        wgt_byte,
   input  logic [OFF_W-1:0]         act_offset,
   input  logic [OFF_W-1:0]         wgt_offset,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [OPND_W-1:0] act_opnd;
   logic signed [OPND_W-1:0] wgt_opnd;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // sign-extend both terms to the operand width and add
   always_comb begin
      act_opnd = $signed({{(OPND_W-BYTE_W){act_byte[BYTE_W-1]}}, act_byte})
               + $signed({act_offset[OFF_W-1], act_offset});
      wgt_opnd = $signed({{(OPND_W-BYTE_W){wgt_byte[BYTE_W-1]}}, wgt_byte})
               + $signed({wgt_offset[OFF_W-1], wgt_offset});
      // signed multiply, inactive lanes contribute zero
      prod_in  = '0;
      if (active) begin
         prod_in = act_opnd * wgt_opnd;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> rtl/odp_adder_tree.sv
// pairwise adder tree over the lane products, registered at the root
`timescale 1ns / 1ps

module odp_adder_tree
   import odp_pkg::*;
#(
   parameter int LANES = 8
) (
   input  logic                                     clock,
   input  logic                                     enable,
   input  logic signed [PROD_W-1:0]                 prod [LANES],
   output logic signed [PROD_W+$clog2(LANES)-1:0]   sum
);

   localparam int SUM_W  = PROD_W + $clog2(LANES);
   localparam int LEVELS = $clog2(LANES);
   localparam int PAD    = 1 << LEVELS;

   logic signed [SUM_W-1:0] node [0:LEVELS][0:PAD-1];
   logic signed [SUM_W-1:0] sum_ff;

   // level zero holds the sign-extended products, the rest halves each level
   always_comb begin
      for (int l = 0; l <= LEVELS; l++) begin
         for (int i = 0; i < PAD; i++) begin
            node[l][i] = '0;
         end
      end
      for (int i = 0; i < LANES; i++) begin
         node[0][i] = SUM_W'(prod[i]);
      end
      for (int l = 0; l < LEVELS; l++) begin
         for (int i = 0; i < (PAD >> (l + 1)); i++) begin
            node[l+1][i] = node[l][2*i] + node[l][2*i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= node[LEVELS][0];
      end
   end

   assign sum = sum_ff;

endmodule

>>> rtl/offset_int8_dot_product.sv
// top level: streaming int8 dot product with zero-point offsets
//
//   channel | direction | ports                                  | beat moves
//   req     | in        | req_valid/req_stall, lanes words       | one word pair
//   rsp     | out       | rsp_valid/rsp_stall, rsp_dot_product   | one dot product
//   csr     | in/out    | psel/penable/pwrite/paddr/pwdata/...   | one register
//
// one beat is taken every cycle while the result register is free or being
// drained; a beat is taken into the input register and passes through the lane
// multipliers, the adder tree and the accumulator to the result register.
// the whole pipeline holds while a result waits under rsp_stall.
// synchronous reset clears the accumulator, element position, configuration
// and all valid flags.
`timescale 1ns / 1ps

module offset_int8_dot_product
   import odp_pkg::*;
#(
   parameter int LANES = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [WORD_W-1:0]        req_activation_lanes,
   input  logic [WORD_W-1:0]        req_weight_lanes,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DOT_W-1:0]  rsp_dot_product,
   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]        pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   localparam int SUM_W = PROD_W + $clog2(LANES);

   cfg_type                 cfg;
   logic                    advance;
   logic                    accept;
   logic                    take;
   logic                    last_now;
   logic [LANES-1:0]        mask_now;

   logic [LEN_W-1:0]        pos_ff;
   logic [LEN_W-1:0]        pos_in;

   stage_ctrl_type          s1_ctrl_ff;
   stage_ctrl_type          s2_ctrl_ff;
   stage_ctrl_type          s3_ctrl_ff;
   logic [LANES-1:0]        s1_mask_ff;
   logic [WORD_W-1:0]       s1_act_ff;
   logic [WORD_W-1:0]       s1_wgt_ff;

   logic signed [PROD_W-1:0] prod [LANES];
   logic signed [SUM_W-1:0]  tree_sum;

   logic [DOT_W-1:0]        acc_ff;
   logic [DOT_W-1:0]        acc_in;
   logic [DOT_W-1:0]        total;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [DOT_W-1:0]        rsp_data_ff;

   // configuration registers
   odp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // pipeline moves unless a result is held under stall
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign take      = accept && (cfg.vec_len != '0);

   // lane masking and final-beat detection from the element position
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         mask_now[j] = (({1'b0, pos_ff} + POS_EXT_W'(j)) < {1'b0, cfg.vec_len});
      end
      last_now = (({1'b0, pos_ff} + POS_EXT_W'(LANES)) >= {1'b0, cfg.vec_len});
      pos_in   = pos_ff;
      if (take) begin
         pos_in = last_now ? '0 : LEN_W'(pos_ff + LEN_W'(LANES));
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         s1_ctrl_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         if (advance) begin
            s1_ctrl_ff.valid <= take;
            s1_ctrl_ff.last  <= last_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mask_ff <= mask_now;
         s1_act_ff  <= req_activation_lanes;
         s1_wgt_ff  <= req_weight_lanes;
      end
   end

   // lane multipliers; lanes past the data words see byte zero
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [BYTE_W-1:0] act_byte;
      logic [BYTE_W-1:0] wgt_byte;

      if (j < WORD_LANES) begin : g_word
         assign act_byte = s1_act_ff[BYTE_W*j +: BYTE_W];
         assign wgt_byte = s1_wgt_ff[BYTE_W*j +: BYTE_W];
      end else begin : g_zero
         assign act_byte = '0;
         assign wgt_byte = '0;
      end

      odp_lane_mul u_lane (
         .clock      (clock),
         .enable     (advance),
         .active     (s1_mask_ff[j]),
         .act_byte   (act_byte),
         .wgt_byte   (wgt_byte),
         .act_offset (cfg.act_offset),
         .wgt_offset (cfg.wgt_offset),
         .prod       (prod[j])
      );
   end

   // reduction
   odp_adder_tree #(
      .LANES (LANES)
   ) u_tree (
      .clock  (clock),
      .enable (advance),
      .prod   (prod),
      .sum    (tree_sum)
   );

   // control follows the datapath stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
      end else if (advance) begin
         s2_ctrl_ff <= s1_ctrl_ff;
         s3_ctrl_ff <= s2_ctrl_ff;
      end
   end

   // wrapping accumulator and result register
   always_comb begin
      total        = acc_ff + DOT_W'(tree_sum);
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s3_ctrl_ff.valid && s3_ctrl_ff.last;
         if (s3_ctrl_ff.valid) begin
            acc_in = s3_ctrl_ff.last ? '0 : total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s3_ctrl_ff.valid && s3_ctrl_ff.last) begin
         rsp_data_ff <= total;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dot_product = $signed(rsp_data_ff);

endmodule

>>> rtl/odp_checker.sv
// port-level checks on the dot product block, bound to the top level
`timescale 1ns / 1ps

module odp_checker
   import odp_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [DOT_W-1:0] rsp_dot_product,
   input logic                    pready
);

   // a held result keeps its value
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_dot_product));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("result beat changed while stalled");

   // a stalled result backs up into the request side
   property p_backpressure;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_stall) |-> req_stall;
   endproperty
   a_backpressure: assert property (p_backpressure)
      else $error("request taken while result held");

   // with no result pending the block always takes a beat
   property p_no_idle_stall;
      @(posedge clock) disable iff (reset)
         !rsp_valid |-> !req_stall;
   endproperty
   a_no_idle_stall: assert property (p_no_idle_stall)
      else $error("request stalled with empty result register");

   // reset leaves no result pending
   property p_reset_clear;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_clear: assert property (p_reset_clear)
      else $error("result valid after reset");

   // register access never waits
   property p_pready;
      @(posedge clock) disable iff (reset) pready;
   endproperty
   a_pready: assert property (p_pready)
      else $error("pready low");

endmodule

bind offset_int8_dot_product odp_checker u_odp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_dot_product (rsp_dot_product),
   .pready          (pready)
);

>>> tb/sv/offset_int8_dot_product_test.sv
// testbench for the offset int8 dot product: directed table, random vectors, self-checking
`timescale 1ns / 1ps

module offset_int8_dot_product_test;
   import odp_pkg::*;

   localparam int RANDOM_BEATS   = 1450;
   localparam int DRAIN_CYCLES   = 10;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PERCENT   = 29;

   typedef enum {CHECK_MODEL, CHECK_VALUE, CHECK_NONE} check_kind_type;

   typedef struct {
      logic [DATA_W-1:0] act_off;
      logic [DATA_W-1:0] wgt_off;
      logic [DATA_W-1:0] vec_len;
      logic [WORD_W-1:0] act;
      logic [WORD_W-1:0] wgt;
      check_kind_type    kind;
      logic [DOT_W-1:0]  dot;
   } dir_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [WORD_W-1:0]  req_activation_lanes;
   logic [WORD_W-1:0]  req_weight_lanes;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [DOT_W-1:0]   rsp_dot_product;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [ADDR_W-1:0]  paddr;
   logic [DATA_W-1:0]  pwdata;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   // predictor state and its copy of the registers
   logic [DOT_W-1:0]   sum_model;
   logic [LEN_W-1:0]   pos_model;
   logic [OFF_W-1:0]   act_off_model;
   logic [OFF_W-1:0]   wgt_off_model;
   logic [LEN_W-1:0]   len_model;
   logic [DATA_W-1:0]  cfg_words [3];

   logic [DOT_W-1:0]   pending_dots [$];
   dir_row_type        directed_rows [$];
   int                 failures;
   int                 idle_cycles;
   bit                 steady;
   bit                 hold_off_req;

   offset_int8_dot_product dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_activation_lanes (req_activation_lanes),
      .req_weight_lanes     (req_weight_lanes),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_dot_product      (rsp_dot_product),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [DOT_W-1:0] got,
                                  input logic [DOT_W-1:0] want);
      $display("mismatch: %s: got %0d, expected %0d", what, $signed(got), $signed(want));
      failures++;
   endtask

   // one beat through the predictor: offset lanes, masked by length, wrapped accumulate
   task automatic accumulate_beat(input logic [WORD_W-1:0] act, input logic [WORD_W-1:0] wgt,
                                  output bit has_dot, output logic [DOT_W-1:0] dot);
      logic signed [OFF_W-1:0]  aoff;
      logic signed [OFF_W-1:0]  woff;
      logic signed [BYTE_W-1:0] abyte;
      logic signed [BYTE_W-1:0] wbyte;
      int                       a;
      int                       w;
      int                       lane_sum;
      has_dot = 1'b0;
      dot = '0;
      aoff = act_off_model;
      woff = wgt_off_model;
      lane_sum = 0;
      if (len_model != 0) begin
         for (int j = 0; j < WORD_LANES; j++) begin
            if (int'(pos_model) + j < int'(len_model)) begin
               abyte = act[BYTE_W*j +: BYTE_W];
               wbyte = wgt[BYTE_W*j +: BYTE_W];
               a = int'(abyte) + int'(aoff);
               w = int'(wbyte) + int'(woff);
               lane_sum += a * w;
            end
         end
         sum_model = sum_model + DOT_W'(lane_sum);
         if (int'(pos_model) + WORD_LANES >= int'(len_model)) begin
            has_dot = 1'b1;
            dot = sum_model;
            sum_model = '0;
            pos_model = '0;
         end else begin
            pos_model = pos_model + LEN_W'(WORD_LANES);
         end
      end
   endtask

   // register write: setup then access, caller sits at a falling edge
   task automatic write_csr(input csr_index_type idx, input logic [DATA_W-1:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = ADDR_W'(4 * int'(idx));
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         CSR_ACT_OFFSET: act_off_model = value[OFF_W-1:0];
         CSR_WGT_OFFSET: wgt_off_model = value[OFF_W-1:0];
         CSR_VEC_LEN:    len_model = value[LEN_W-1:0];
         default: ;
      endcase
      cfg_words[int'(idx)] = value;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // hold the sender until every result is back and the pipeline is empty
   task automatic drain_pipeline();
      req_valid = 1'b0;
      while (pending_dots.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [DATA_W-1:0] aoff, input logic [DATA_W-1:0] woff,
                             input logic [DATA_W-1:0] len);
      drain_pipeline();
      write_csr(CSR_ACT_OFFSET, aoff);
      write_csr(CSR_WGT_OFFSET, woff);
      write_csr(CSR_VEC_LEN, len);
   endtask

   // offer one beat, wait for it to be taken, then record what it should produce
   task automatic send_beat(input logic [WORD_W-1:0] act, input logic [WORD_W-1:0] wgt,
                            input check_kind_type kind, input logic [DOT_W-1:0] typed);
      bit               has_dot;
      logic [DOT_W-1:0] dot;
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_activation_lanes = act;
      req_weight_lanes = wgt;
      do @(posedge clock); while (req_stall);
      accumulate_beat(act, wgt, has_dot, dot);
      case (kind)
         CHECK_MODEL: if (has_dot) pending_dots.push_back(dot);
         CHECK_VALUE: pending_dots.push_back(typed);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic add_row(input logic [DATA_W-1:0] aoff, input logic [DATA_W-1:0] woff,
                          input logic [DATA_W-1:0] len, input logic [WORD_W-1:0] act,
                          input logic [WORD_W-1:0] wgt, input check_kind_type kind,
                          input logic [DOT_W-1:0] dot);
      dir_row_type row;
      row.act_off = aoff;
      row.wgt_off = woff;
      row.vec_len = len;
      row.act = act;
      row.wgt = wgt;
      row.kind = kind;
      row.dot = dot;
      directed_rows.push_back(row);
   endtask

   // random lanes, weighted toward the byte extremes
   function automatic logic [WORD_W-1:0] random_lanes();
      logic [WORD_W-1:0] word;
      for (int j = 0; j < WORD_LANES; j++) begin
         case ($urandom_range(0, 9))
            0: word[BYTE_W*j +: BYTE_W] = 8'h80;
            1: word[BYTE_W*j +: BYTE_W] = 8'h7F;
            2: word[BYTE_W*j +: BYTE_W] = 8'h00;
            3: word[BYTE_W*j +: BYTE_W] = 8'hFF;
            default: word[BYTE_W*j +: BYTE_W] = BYTE_W'($urandom);
         endcase
      end
      return word;
   endfunction

   // offsets: extremes, zero, any bit pattern, or in range
   function automatic logic [DATA_W-1:0] random_offset();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'h0000_0180;
      if (r < 30) return 32'h0000_0080;
      if (r < 38) return '0;
      if (r < 45) return $urandom;
      return DATA_W'(int'($urandom_range(0, 256)) - 128);
   endfunction

   function automatic logic [DATA_W-1:0] random_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return 32'd65535;
      if (r < 22) return $urandom_range(1, 8);
      if (r < 80) return $urandom_range(9, 64);
      return $urandom_range(65, 300);
   endfunction

   // receiver: random stalls, or one long hold-off when the sender asks
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_stall = !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_dots.size() == 0)
               report_mismatch("dot product with none pending", rsp_dot_product, '0);
            else if (rsp_dot_product !== pending_dots[0])
               report_mismatch("dot product", rsp_dot_product, pending_dots.pop_front());
            else
               void'(pending_dots.pop_front());
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results pending",
                     idle_cycles, pending_dots.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int beats_done;
      int phase_no;
      int vectors;
      int beats;
      logic [DATA_W-1:0] len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_activation_lanes = '0;
      req_weight_lanes = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      failures = 0;
      idle_cycles = 0;
      steady = 1'b0;
      hold_off_req = 1'b0;
      sum_model = '0;
      pos_model = '0;
      act_off_model = '0;
      wgt_off_model = '0;
      len_model = '0;
      foreach (cfg_words[i]) cfg_words[i] = '0;

      // full-lane extremes with no offsets
      add_row(0, 0, 8, {8{8'h7F}}, {8{8'h7F}}, CHECK_VALUE, 129032);
      add_row(0, 0, 8, {8{8'h80}}, {8{8'h80}}, CHECK_VALUE, 131072);
      add_row(0, 0, 8, {8{8'h80}}, {8{8'h7F}}, CHECK_VALUE, -130048);
      add_row(0, 0, 8, {8{8'hFF}}, {8{8'h01}}, CHECK_VALUE, -8);
      // zero length ignores beats
      add_row(0, 0, 0, {8{8'h7F}}, {8{8'h7F}}, CHECK_NONE, 0);
      add_row(0, 0, 0, {8{8'h80}}, {8{8'h80}}, CHECK_NONE, 0);
      // offset extremes, negative offsets written sign-extended
      add_row(32'h80, 32'h80, 8, {8{8'h7F}}, {8{8'h7F}}, CHECK_VALUE, 520200);
      add_row(32'hFFFF_FF80, 32'hFFFF_FF80, 8, {8{8'h80}}, {8{8'h80}}, CHECK_VALUE, 524288);
      add_row(32'h180, 32'h80, 8, {8{8'h80}}, {8{8'h7F}}, CHECK_VALUE, -522240);
      // offsets outside the nominal range use their 9-bit signed value
      add_row(32'h17F, 32'h001, 8, '0, '0, CHECK_VALUE, -1032);
      add_row(32'h0FF, 32'h1FF, 8, '0, '0, CHECK_VALUE, -2040);
      // partial lanes
      add_row(0, 0, 3, {8{8'h7F}}, {8{8'h01}}, CHECK_VALUE, 381);
      add_row(0, 0, 1, 64'h1111_1111_1111_1180, 64'h2222_2222_2222_2280, CHECK_VALUE, 16384);
      // multi-beat vectors, ragged and exact
      add_row(5, 32'h1FD, 20, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, CHECK_MODEL, 0);
      add_row(5, 32'h1FD, 20, 64'h8081_7F7E_0001_FFFE, 64'h7F80_0102_FDFC_5A5A, CHECK_MODEL, 0);
      add_row(5, 32'h1FD, 20, 64'hA5A5_A5A5_5A5A_5A5A, 64'h3C3C_C3C3_0F0F_F0F0, CHECK_MODEL, 0);
      add_row(0, 0, 16, 64'h7F7F_8080_7F7F_8080, 64'h8080_7F7F_8080_7F7F, CHECK_MODEL, 0);
      add_row(0, 0, 16, 64'hFFFF_0000_FFFF_0000, 64'h0101_0101_FFFF_FFFF, CHECK_MODEL, 0);
      // length lowered below the position mid-vector: next beat is final
      add_row(7, 2, 20, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321, CHECK_MODEL, 0);
      add_row(7, 2, 5, 64'h7F7F_7F7F_7F7F_7F7F, 64'h7F7F_7F7F_7F7F_7F7F, CHECK_MODEL, 0);
      // maximum length, flushed by lowering it
      add_row(0, 0, 65535, {8{8'h80}}, {8{8'h80}}, CHECK_MODEL, 0);
      add_row(0, 0, 65535, {8{8'h7F}}, {8{8'h80}}, CHECK_MODEL, 0);
      add_row(0, 0, 1, {8{8'h55}}, {8{8'hAA}}, CHECK_MODEL, 0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].act_off !== cfg_words[CSR_ACT_OFFSET] ||
             directed_rows[i].wgt_off !== cfg_words[CSR_WGT_OFFSET] ||
             directed_rows[i].vec_len !== cfg_words[CSR_VEC_LEN])
            set_config(directed_rows[i].act_off, directed_rows[i].wgt_off,
                       directed_rows[i].vec_len);
         send_beat(directed_rows[i].act, directed_rows[i].wgt, directed_rows[i].kind,
                   directed_rows[i].dot);
      end

      // random phases of whole vectors, some cut short
      beats_done = 0;
      phase_no = 0;
      while (beats_done < RANDOM_BEATS) begin
         drain_pipeline();
         steady = (beats_done >= 500 && beats_done < 700);
         if (phase_no == 6) begin
            // long receiver hold-off while the sender keeps offering
            set_config(random_offset(), random_offset(), 8);
            steady = 1'b1;
            hold_off_req = 1'b1;
            for (int i = 0; i < 40; i++) begin
               send_beat(random_lanes(), random_lanes(), CHECK_MODEL, '0);
               beats_done++;
            end
         end else begin
            len = random_length();
            set_config(random_offset(), random_offset(), len);
            vectors = $urandom_range(1, 4);
            for (int v = 0; v < vectors; v++) begin
               if (len == 0) beats = $urandom_range(1, 3);
               else if (len > 300) beats = $urandom_range(1, 6);
               else beats = (int'(len) + 7) / 8;
               if (len != 0 && $urandom_range(0, 9) == 0) beats = $urandom_range(1, beats);
               for (int i = 0; i < beats; i++) begin
                  send_beat(random_lanes(), random_lanes(), CHECK_MODEL, '0);
                  if (len != 0) beats_done++;
               end
            end
         end
         phase_no++;
      end

      steady = 1'b0;
      drain_pipeline();
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
